// ===== sv/tpp_pkg.sv =====
// shared constants and types of the transport stream pcr pacer
`default_nettype none
package tpp_pkg;

  localparam logic [7:0] LAST_POS      = 8'd187;
  localparam logic [7:0] POS_SYNC      = 8'd0;
  localparam logic [7:0] POS_AF_CTRL   = 8'd3;
  localparam logic [7:0] POS_AF_LEN    = 8'd4;
  localparam logic [7:0] POS_AF_FLAGS  = 8'd5;
  localparam logic [7:0] POS_PCR_FIRST = 8'd6;
  localparam logic [7:0] POS_PCR_LAST  = 8'd11;

  localparam logic [7:0] SYNC_BYTE   = 8'h47;
  localparam logic [7:0] MIN_AF_LEN  = 8'd7;
  localparam int unsigned AF_CTRL_BIT  = 5;
  localparam int unsigned PCR_FLAG_BIT = 4;

  localparam logic [7:0]  REG_PACE_ENABLE  = 8'd0;
  localparam logic [7:0]  REG_REANCHOR_GAP = 8'd1;
  localparam logic        PACE_ENABLE_RESET = 1'b1;
  localparam logic [41:0] GAP_RESET         = 42'd27000000;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // ticks to ns: off*1000/27 = off*37 + off/27, and off/27 = (off*RECIP) >> 45
  localparam int unsigned ACC_W       = 83;
  localparam int unsigned RECIP_SHIFT = 45;
  localparam logic [31:0] RECIP_LO    = 32'h684B_DA13;
  localparam logic [31:0] RECIP_HI    = 32'h0000_012F;
  localparam logic [41:0] PCR_MULT    = 42'd300;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [63:0] now_time;
    logic        pcr_ready;
    logic        pkt_end;
    logic        pcr_ok;
    logic [47:0] pcr_bytes;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/tpp_front.sv =====
// front: byte position tracking and header parsing
`default_nettype none
module tpp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic [63:0]    now_time,
  input  logic           q_full,
  output logic           push,
  output tpp_pkg::item_t push_item
);
  import tpp_pkg::*;

  logic [7:0]  byte_position;
  logic [7:0]  byte_position_next;
  logic        sync_ok, sync_ok_next;
  logic        adapt_present, adapt_present_next;
  logic        adapt_long_enough, adapt_long_enough_next;
  logic        pcr_flag_seen, pcr_flag_seen_next;
  logic [47:0] pcr_bytes, pcr_bytes_next;
  logic        pkt_end;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign pkt_end  = byte_position >= LAST_POS;

  always_comb begin
    sync_ok_next           = sync_ok;
    adapt_present_next     = adapt_present;
    adapt_long_enough_next = adapt_long_enough;
    pcr_flag_seen_next     = pcr_flag_seen;
    pcr_bytes_next         = pcr_bytes;
    if (byte_position == POS_SYNC) begin
      sync_ok_next = data_byte == SYNC_BYTE;
    end else if (byte_position == POS_AF_CTRL) begin
      adapt_present_next = data_byte[AF_CTRL_BIT];
    end else if (byte_position == POS_AF_LEN) begin
      adapt_long_enough_next = data_byte >= MIN_AF_LEN;
    end else if (byte_position == POS_AF_FLAGS) begin
      pcr_flag_seen_next = data_byte[PCR_FLAG_BIT];
    end else if (byte_position >= POS_PCR_FIRST && byte_position <= POS_PCR_LAST) begin
      pcr_bytes_next = {pcr_bytes[39:0], data_byte};
    end
    byte_position_next = pkt_end ? 8'd0 : byte_position + 8'd1;
  end

  always_comb begin
    push_item.data_byte = data_byte;
    push_item.now_time  = now_time;
    push_item.pcr_ready = byte_position == POS_PCR_LAST;
    push_item.pkt_end   = pkt_end;
    push_item.pcr_ok    = sync_ok_next && adapt_present_next && adapt_long_enough_next
                          && pcr_flag_seen_next;
    push_item.pcr_bytes = pcr_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 8'd0;
      sync_ok           <= 1'b0;
      adapt_present     <= 1'b0;
      adapt_long_enough <= 1'b0;
      pcr_flag_seen     <= 1'b0;
      pcr_bytes         <= 48'd0;
    end else if (push) begin
      byte_position     <= byte_position_next;
      sync_ok           <= sync_ok_next;
      adapt_present     <= adapt_present_next;
      adapt_long_enough <= adapt_long_enough_next;
      pcr_flag_seen     <= pcr_flag_seen_next;
      pcr_bytes         <= pcr_bytes_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tpp_queue.sv =====
// short item queue between front and back
`default_nettype none
module tpp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tpp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tpp_pkg::item_t head_item
);
  import tpp_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + QCNT_W'(1);
    else if (pop && !push) count_next = count - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tpp_back.sv =====
// back: pcr arithmetic, anchoring and result register
`default_nettype none
module tpp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tpp_pkg::item_t head_item,
  output logic           pop,
  input  logic           pace_enable,
  input  logic [41:0]    reanchor_gap,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           packet_end,
  output logic           pcr_seen,
  output logic [41:0]    pcr_value,
  output logic [63:0]    release_time,
  output logic           reanchored
);
  import tpp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_RECIP = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;

  logic [2:0]       mstate;
  logic [47:0]      raw;
  logic [41:0]      pcr;
  logic [41:0]      pcr_calc;
  logic [41:0]      off;
  logic [47:0]      off_x37;
  logic [47:0]      off_x37_calc;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] acc;
  logic [1:0]       step;
  logic [63:0]      wall_part;
  logic             backward;
  logic [41:0]      diff;
  logic [63:0]      sum;

  logic                anchored;
  logic [41:0]         anchor_pcr;
  logic [63:0]         anchor_wall;
  logic [41:0]         previous_pcr;

  logic                fin;
  logic                reanch;

  assign pcr_calc     = ({9'd0, raw[47:15]} * PCR_MULT) + {33'd0, raw[8:0]};
  assign off_x37_calc = {1'b0, off, 5'd0} + {4'd0, off, 2'd0} + {6'd0, off};

  // four partial products of off * reciprocal, lo*lo, lo*hi, hi*lo, hi*hi
  assign mul_a  = step[1] ? {22'd0, off[41:32]} : off[31:0];
  assign mul_b  = step[0] ? RECIP_HI : RECIP_LO;
  assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
  assign addend = {19'd0, mul_p} << {step[1] & step[0], step[1] ^ step[0], 5'd0};

  assign fin    = head_item.pkt_end && head_item.pcr_ok;
  assign reanch = pace_enable && (!anchored || (backward && diff > reanchor_gap));
  assign pop    = head_valid && (!out_valid || out_ready) && !(fin && mstate != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= ST_IDLE;
    end else begin
      unique case (mstate)
        ST_IDLE: begin
          if (pop && head_item.pcr_ready) begin
            raw    <= head_item.pcr_bytes;
            mstate <= ST_MUL;
          end
        end
        ST_MUL: begin
          pcr    <= pcr_calc;
          mstate <= ST_PREP;
        end
        ST_PREP: begin
          off      <= (pcr >= anchor_pcr) ? pcr - anchor_pcr : 42'd0;
          backward <= anchored && (pcr < previous_pcr);
          diff     <= previous_pcr - pcr;
          mstate   <= ST_SCALE;
        end
        ST_SCALE: begin
          off_x37 <= off_x37_calc;
          acc     <= '0;
          step    <= '0;
          mstate  <= ST_RECIP;
        end
        ST_RECIP: begin
          acc       <= acc + addend;
          wall_part <= anchor_wall + {16'd0, off_x37};
          step      <= step + 2'd1;
          if (step == 2'd3) mstate <= ST_SUM;
        end
        ST_SUM: begin
          sum    <= wall_part + {26'd0, acc[ACC_W-1:RECIP_SHIFT]};
          mstate <= ST_IDLE;
        end
        default: mstate <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchored     <= 1'b0;
      anchor_pcr   <= 42'd0;
      anchor_wall  <= 64'd0;
      previous_pcr <= 42'd0;
    end else if (pop && fin && pace_enable) begin
      previous_pcr <= pcr;
      if (reanch) begin
        anchored    <= 1'b1;
        anchor_pcr  <= pcr;
        anchor_wall <= head_item.now_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte     <= head_item.data_byte;
      packet_end   <= head_item.pkt_end;
      pcr_seen     <= fin;
      pcr_value    <= fin ? pcr : 42'd0;
      release_time <= (fin && pace_enable) ? (reanch ? head_item.now_time : sum) : 64'd0;
      reanchored   <= fin && reanch;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ts_pcr_pacer_unit.sv =====
// top level of the transport stream pcr pacer
// Takes one transport stream byte per cycle while the queue has room and gives one result per
// byte; each result passes through the queue and then the result register. The byte
// position counter and header parser sit in the front; a four-item queue feeds the back,
// where a shared arithmetic unit works out the pcr and its release time (pcr multiply,
// offset, scale by 37, a four-step reciprocal multiply for the remaining division by 27,
// anchor add). It starts once the last pcr byte has passed and overlaps the 176 bytes that
// remain in the packet, so a steady stream runs at one byte per cycle while the output is
// not stalled.
`default_nettype none
module ts_pcr_pacer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [63:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_end,
  output logic        pcr_seen,
  output logic [41:0] pcr_value,
  output logic [63:0] release_time,
  output logic        reanchored,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tpp_pkg::*;

  logic        pace_enable;
  logic [41:0] reanchor_gap;
  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  item_t       head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pace_enable  <= PACE_ENABLE_RESET;
      reanchor_gap <= GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PACE_ENABLE:  pace_enable  <= cfg_data[0];
        REG_REANCHOR_GAP: reanchor_gap <= cfg_data[41:0];
        default: ;
      endcase
    end
  end

  tpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .now_time  (now_time),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .pace_enable  (pace_enable),
    .reanchor_gap (reanchor_gap),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .packet_end   (packet_end),
    .pcr_seen     (pcr_seen),
    .pcr_value    (pcr_value),
    .release_time (release_time),
    .reanchored   (reanchored)
  );

endmodule
`default_nettype wire

// ===== sv/tpp_checker.sv =====
// port checker for the pcr pacer and its bind
`default_nettype none
module tpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        packet_end,
  input logic        pcr_seen,
  input logic [41:0] pcr_value,
  input logic [63:0] release_time,
  input logic        reanchored
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(release_time))
    else $error("result item changed while stalled");

  a_pcr_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && pcr_seen |-> packet_end)
    else $error("pcr reported away from packet end");

  a_reanchor_pcr: assert property (@(posedge clk) disable iff (rst)
    out_valid && reanchored |-> pcr_seen)
    else $error("reanchor without pcr");

  a_no_pcr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pcr_seen |-> pcr_value == 42'd0 && release_time == 64'd0)
    else $error("pcr fields set without pcr");

endmodule

bind ts_pcr_pacer_unit tpp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .packet_end   (packet_end),
  .pcr_seen     (pcr_seen),
  .pcr_value    (pcr_value),
  .release_time (release_time),
  .reanchored   (reanchored)
);
`default_nettype wire
